// ===== src/jss_pkg.sv =====
// ----------------------------------------------------------------------------
// jss_pkg
// Shared widths, word types and register indexes of the Jacobi stencil sweep.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int VAL_W    = 32;  // signed Q16.16 grid value
  localparam int CHG_W    = 31;  // unsigned Q15.16 change
  localparam int ROWS_W   = 16;
  localparam int COLS_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 31;

  localparam logic [CHG_W-1:0] CHG_SAT = {CHG_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS     = 2'd0,
    CFG_COLS     = 2'd1,
    CFG_INIT_MAX = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_value;
    logic [CHG_W-1:0]        abs_change;
    logic [CHG_W-1:0]        max_change;
    logic                    last_point;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
  } cfg_word_t;

endpackage

// ===== src/jss_chan_if.sv =====
// ----------------------------------------------------------------------------
// jss_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface jss_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== src/jacobi_stencil_sweep_max_change_top.sv =====
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep_max_change_top
// 4-point Jacobi stencil over a streamed frame with running max of change.
//
//   channel  dir  payload                                         handshake
//   in_if    in   sample                                          valid/ready
//   out_if   out  new_value, abs_change, max_change, last_point   valid/ready
//   cfg_if   in   index, wdata                                    valid/ready
//
// one word per cycle while out_ready keeps the pipeline moving; a result word
// passes the operand, sum, change and output registers before it is offered
// line buffers (prev row dual-read, older row single-read, single-write) are
// prefetched one column ahead; each word finds its neighbors already registered
// reset clears counters and pipeline, presets config; line buffers not cleared
// out_ready low fills the pipeline; in_ready drops only when all stages hold
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep_max_change_top
  import jss_pkg::*;
#(
  parameter int MAX_COLS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  jss_chan_if.sink   in_if,
  jss_chan_if.source out_if,
  jss_chan_if.sink   cfg_if
);

  localparam int DEPTH = MAX_COLS + 2;
  localparam int CNTW  = $clog2(DEPTH);
  localparam int XW    = (CNTW > COLS_W) ? CNTW : COLS_W;

  typedef struct packed {
    logic signed [VAL_W-1:0] up;
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] mid;
    logic signed [VAL_W-1:0] right;
    logic signed [VAL_W-1:0] down;
    logic                    prod;
    logic                    last;
    logic                    start;
  } stage_a_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] nv;
    logic signed [VAL_W-1:0] mid;
    logic                    prod;
    logic                    last;
    logic                    start;
  } stage_b_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] nv;
    logic [CHG_W-1:0]        ch;
    logic                    prod;
    logic                    last;
    logic                    start;
  } stage_c_t;

  // configuration
  logic [ROWS_W-1:0] rows_r;
  logic [COLS_W-1:0] cols_r;
  logic [CHG_W-1:0]  init_max_r;

  // frame position
  logic [ROWS_W:0]   row_r, row_nxt;
  logic [CNTW-1:0]   col_r, col_nxt;
  logic [ROWS_W:0]   rows_eff, rows_p1;
  logic [XW-1:0]     cols_x;
  logic [CNTW-1:0]   cols_eff, cols_p1;
  logic              at_wrap;

  // line buffers
  logic [VAL_W-1:0]  older_mem [DEPTH];
  logic [VAL_W-1:0]  prev_mem  [DEPTH];
  logic [CNTW-1:0]   ra0, ra1;
  logic [VAL_W-1:0]  o_rd_r, p0_rd_r, p1_rd_r, left_r;

  // pipeline
  logic              in_acc;
  logic              rdy_a, rdy_b, rdy_c, rdy_o;
  logic              va_r, vb_r, vc_r, ov_r;
  stage_a_t          a_r, a_nxt;
  stage_b_t          b_r, b_nxt;
  stage_c_t          c_r, c_nxt;
  out_word_t         o_r;
  logic [CHG_W-1:0]  run_max_r, max_nxt;

  logic signed [VAL_W+1:0] sum;
  logic [VAL_W:0]          diff, adiff;

  // ---------------------------------------------------------------- config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= ROWS_W'(1);
      cols_r     <= COLS_W'(1);
      init_max_r <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_t'(cfg_if.payload.index))
        CFG_ROWS:     rows_r     <= cfg_if.payload.wdata[ROWS_W-1:0];
        CFG_COLS:     cols_r     <= cfg_if.payload.wdata[COLS_W-1:0];
        CFG_INIT_MAX: init_max_r <= cfg_if.payload.wdata[CHG_W-1:0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------- frame position
  always_comb begin
    rows_eff = (rows_r == '0) ? (ROWS_W+1)'(1) : {1'b0, rows_r};
    rows_p1  = rows_eff + (ROWS_W+1)'(1);
    cols_x   = XW'(cols_r);
    if (cols_r == '0) begin
      cols_eff = CNTW'(1);
    end else if (cols_x > XW'(MAX_COLS)) begin
      cols_eff = CNTW'(MAX_COLS);
    end else begin
      cols_eff = cols_x[CNTW-1:0];
    end
    cols_p1 = cols_eff + CNTW'(1);
    at_wrap = (col_r >= cols_p1);
  end

  assign in_acc = in_if.valid && rdy_a;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (at_wrap) begin
        col_nxt = '0;
        row_nxt = (row_r >= rows_p1) ? '0 : row_r + (ROWS_W+1)'(1);
      end else begin
        col_nxt = col_r + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ------------------------------------------------------- line buffers
  // read ahead at the column of the next word; never collides with the write
  always_comb begin
    ra0 = rst_n ? col_nxt : '0;
    ra1 = (ra0 == CNTW'(DEPTH - 1)) ? ra0 : ra0 + CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (in_acc && rst_n) begin
      older_mem[col_r] <= p0_rd_r;
      prev_mem[col_r]  <= in_if.payload.sample;
    end
    o_rd_r  <= older_mem[ra0];
    p0_rd_r <= prev_mem[ra0];
    p1_rd_r <= prev_mem[ra1];
  end

  // left neighbor is the previous-row word moved to the older row one step ago
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r <= p0_rd_r;
    end
  end

  // ------------------------------------------------------------ pipeline
  assign rdy_o = !ov_r || out_if.ready;
  assign rdy_c = !vc_r || rdy_o;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_if.ready = rdy_a;

  always_comb begin
    a_nxt.up    = o_rd_r;
    a_nxt.left  = left_r;
    a_nxt.mid   = p0_rd_r;
    a_nxt.right = p1_rd_r;
    a_nxt.down  = in_if.payload.sample;
    a_nxt.prod  = (row_r >= (ROWS_W+1)'(2)) && (row_r <= rows_p1) &&
                  (col_r != '0) && (col_r <= cols_eff);
    a_nxt.last  = (row_r == rows_p1) && (col_r == cols_eff);
    a_nxt.start = (row_r == '0) && (col_r == '0);
  end

  // sum in 34 bits, arithmetic shift by 2 keeps bits 33:2
  always_comb begin
    sum = {{2{a_r.up[VAL_W-1]}}, a_r.up} + {{2{a_r.left[VAL_W-1]}}, a_r.left} +
          {{2{a_r.right[VAL_W-1]}}, a_r.right} + {{2{a_r.down[VAL_W-1]}}, a_r.down};
    b_nxt.nv    = sum[VAL_W+1:2];
    b_nxt.mid   = a_r.mid;
    b_nxt.prod  = a_r.prod;
    b_nxt.last  = a_r.last;
    b_nxt.start = a_r.start;
  end

  always_comb begin
    diff  = {b_r.nv[VAL_W-1], b_r.nv} - {b_r.mid[VAL_W-1], b_r.mid};
    adiff = diff[VAL_W] ? (~diff + (VAL_W+1)'(1)) : diff;
    c_nxt.nv    = b_r.nv;
    c_nxt.ch    = (adiff[VAL_W:CHG_W] != '0) ? CHG_SAT : adiff[CHG_W-1:0];
    c_nxt.prod  = b_r.prod;
    c_nxt.last  = b_r.last;
    c_nxt.start = b_r.start;
  end

  always_comb begin
    if (c_r.start) begin
      max_nxt = init_max_r;
    end else if (c_r.prod && (c_r.ch > run_max_r)) begin
      max_nxt = c_r.ch;
    end else begin
      max_nxt = run_max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      vc_r      <= 1'b0;
      ov_r      <= 1'b0;
      run_max_r <= '0;
    end else begin
      if (rdy_a) va_r <= in_if.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_o) ov_r <= vc_r && c_r.prod;
      if (rdy_o && vc_r) run_max_r <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) a_r <= a_nxt;
    if (rdy_b)  b_r <= b_nxt;
    if (rdy_c)  c_r <= c_nxt;
    if (rdy_o) begin
      o_r.new_value  <= c_r.nv;
      o_r.abs_change <= c_r.ch;
      o_r.max_change <= max_nxt;
      o_r.last_point <= c_r.last;
    end
  end

  assign out_if.valid   = ov_r;
  assign out_if.payload = o_r;

endmodule

// ===== src/jss_checker.sv =====
// ----------------------------------------------------------------------------
// jss_checker
// Port-level assertions for the Jacobi stencil sweep, bound to the top level.
// ----------------------------------------------------------------------------
module jss_checker
  import jss_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // the running max covers the change it includes
  a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.max_change >= out_word.abs_change)
    else $error("max_change below abs_change");

  // a draining output never backs up the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind jacobi_stencil_sweep_max_change_top jss_checker u_jss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_word  (out_if.payload)
);
